// ===== hw/rtl/slt_pkg.sv =====
// types and codes shared by the sorted list table
`timescale 1ns / 1ps

package slt_pkg;

  typedef enum logic [1:0] {
    ACT_INSERT  = 2'd0,
    ACT_DEL_POS = 2'd1,
    ACT_SEARCH  = 2'd2,
    ACT_DEL_KEY = 2'd3
  } action_t;

  localparam logic [1:0] ST_DONE = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  typedef struct packed {
    logic [1:0]         action;
    logic signed [31:0] value;
    logic [4:0]         position;
  } in_word_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [4:0]         found_position;
    logic signed [31:0] removed_value;
  } out_word_t;

  // classified request as held in the queue
  typedef struct packed {
    action_t            op;
    logic signed [31:0] value;
    logic [4:0]         pidx;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

// ===== hw/rtl/slt_front.sv =====
// request intake: accepts words, classifies them and hands them to the queue
`timescale 1ns / 1ps

module slt_front
  import slt_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_word_t  in_word,
  input  q_status_t q_status,
  output logic      push,
  output cmd_t      push_cmd
);

  logic hold_valid_r, hold_valid_nxt;
  cmd_t hold_cmd_r, hold_cmd_nxt;
  logic take;

  assign push     = hold_valid_r && !q_status.full;
  assign push_cmd = hold_cmd_r;
  assign busy     = hold_valid_r && q_status.full;
  assign take     = start && !busy;

  always_comb begin
    hold_valid_nxt = hold_valid_r;
    hold_cmd_nxt   = hold_cmd_r;
    if (push) begin
      hold_valid_nxt = 1'b0;
    end
    if (take) begin
      hold_valid_nxt     = 1'b1;
      hold_cmd_nxt.op    = action_t'(in_word.action);
      hold_cmd_nxt.value = in_word.value;
      // position zero acts as the first position
      hold_cmd_nxt.pidx  = (in_word.position == 5'd0) ? 5'd0 : in_word.position - 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
    end else begin
      hold_valid_r <= hold_valid_nxt;
    end
    hold_cmd_r <= hold_cmd_nxt;
  end

endmodule

// ===== hw/rtl/slt_queue.sv =====
// two-entry queue between intake and execution
`timescale 1ns / 1ps

module slt_queue
  import slt_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  cmd_t      push_cmd,
  input  logic      pop,
  output cmd_t      head,
  output q_status_t q_status
);

  cmd_t       slot_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign head           = slot_r[rd_ptr_r];
  assign q_status.full  = (cnt_r == 2'd2);
  assign q_status.empty = (cnt_r == 2'd0);

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// ===== hw/rtl/slt_back.sv =====
// execution: row of entry cells with per-cell compare and shift
`timescale 1ns / 1ps

module slt_back
  import slt_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  cmd_t      head,
  input  q_status_t q_status,
  output logic      pop,
  output logic      out_valid,
  output out_word_t out_word
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int PW = (CW > 5) ? CW : 5;

  typedef enum logic [1:0] {
    S_IDLE  = 2'b01,
    S_APPLY = 2'b10
  } state_t;

  state_t                    state_r, state_nxt;
  logic signed [31:0]        entry_r [DEPTH];
  logic signed [31:0]        entry_nxt [DEPTH];
  logic [CW-1:0]             count_r, count_nxt;
  cmd_t                      cmd_r;
  logic [DEPTH-1:0]          ge_r, eq_r, ge_w, eq_w;
  logic                      out_valid_r;
  out_word_t                 out_word_r, out_word_nxt;

  logic                      full, hit, pos_ok;
  logic [DEPTH-1:0]          first;
  logic [CW-1:0]             fpos;
  logic signed [31:0]        pos_val;

  assign pop       = (state_r == S_IDLE) && !q_status.empty;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // compare every valid cell against the key of the waiting word
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      ge_w[i] = (CW'(i) < count_r) && (entry_r[i] >= head.value);
      eq_w[i] = (CW'(i) < count_r) && (entry_r[i] == head.value);
    end
  end

  always_comb begin
    full   = (count_r >= CW'(DEPTH));
    hit    = |eq_r;
    pos_ok = PW'(cmd_r.pidx) < PW'(count_r);
    fpos   = '0;
    pos_val = '0;
    for (int i = 0; i < DEPTH; i++) begin
      first[i] = eq_r[i] && ((i == 0) ? 1'b1 : !eq_r[(i == 0) ? 0 : i - 1]);
      if (first[i]) begin
        fpos = fpos | CW'(i + 1);
      end
      if (PW'(cmd_r.pidx) == PW'(i)) begin
        pos_val = pos_val | entry_r[i];
      end
    end
  end

  always_comb begin
    state_nxt    = state_r;
    count_nxt    = count_r;
    out_word_nxt = out_word_r;
    for (int i = 0; i < DEPTH; i++) begin
      entry_nxt[i] = entry_r[i];
    end
    case (state_r)
      S_IDLE: begin
        if (!q_status.empty) begin
          state_nxt = S_APPLY;
        end
      end
      S_APPLY: begin
        state_nxt                   = S_IDLE;
        out_word_nxt.status         = ST_DONE;
        out_word_nxt.found_position = '0;
        out_word_nxt.removed_value  = '0;
        case (cmd_r.op)
          ACT_INSERT: begin
            if (full) begin
              out_word_nxt.status = ST_FULL;
            end else begin
              count_nxt = count_r + CW'(1);
              for (int i = 0; i < DEPTH; i++) begin
                if (i > 0 && ge_r[(i == 0) ? 0 : i - 1]) begin
                  entry_nxt[i] = entry_r[(i == 0) ? 0 : i - 1];
                end else if (ge_r[i] || CW'(i) == count_r) begin
                  entry_nxt[i] = cmd_r.value;
                end
              end
            end
          end
          ACT_DEL_POS: begin
            if (!pos_ok) begin
              out_word_nxt.status = ST_MISS;
            end else begin
              count_nxt                  = count_r - CW'(1);
              out_word_nxt.removed_value = pos_val;
              for (int i = 0; i < DEPTH - 1; i++) begin
                if (PW'(i) >= PW'(cmd_r.pidx)) begin
                  entry_nxt[i] = entry_r[i + 1];
                end
              end
            end
          end
          ACT_SEARCH: begin
            if (!hit) begin
              out_word_nxt.status = ST_MISS;
            end else begin
              out_word_nxt.found_position = 5'(fpos);
            end
          end
          ACT_DEL_KEY: begin
            if (!hit) begin
              out_word_nxt.status = ST_MISS;
            end else begin
              count_nxt                  = count_r - CW'(1);
              out_word_nxt.removed_value = cmd_r.value;
              for (int i = 0; i < DEPTH - 1; i++) begin
                if (ge_r[i]) begin
                  entry_nxt[i] = entry_r[i + 1];
                end
              end
            end
          end
          default: begin
            out_word_nxt.status = ST_MISS;
          end
        endcase
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= (state_r == S_APPLY);
    end
    out_word_r <= out_word_nxt;
    for (int i = 0; i < DEPTH; i++) begin
      entry_r[i] <= entry_nxt[i];
    end
    if (pop) begin
      cmd_r <= head;
      ge_r  <= ge_w;
      eq_r  <= eq_w;
    end
  end

endmodule

// ===== hw/rtl/sorted_list_table_unit.sv =====
// top level of the sorted list table
`timescale 1ns / 1ps
//
// keeps up to DEPTH signed values in ascending order; one result word per request
// input: a word is taken at a rising edge with start high and busy low
//   in_word carries action, value and position
// output: out_valid is high for exactly one cycle with the result in out_word;
//   the receiver cannot stall, so results never back up
// intake registers the word and passes it into a two-entry queue; execution
//   compares every cell against the key as it takes the word from the queue,
//   registers the outcome, then shifts the row of cells and forms the result
// an accepted word passes through the intake hold register, a queue slot, the
//   command and compare registers and the result register before out_valid;
//   execution takes the next request only after the apply step of the last one
// busy rises only when the queue is full and a word is still held at intake
// reset: synchronous, active low; the table comes up empty, the queue empty,
//   and no result is pending
//
module sorted_list_table_unit
  import slt_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_word_t  in_word,
  output logic      out_valid,
  output out_word_t out_word
);

  q_status_t q_status;
  logic      push, pop;
  cmd_t      push_cmd, head;

  slt_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_word  (in_word),
    .q_status (q_status),
    .push     (push),
    .push_cmd (push_cmd)
  );

  slt_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .q_status (q_status)
  );

  slt_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .q_status  (q_status),
    .pop       (pop),
    .out_valid (out_valid),
    .out_word  (out_word)
  );

endmodule
